>>> design/poa_pkg.sv
`timescale 1ns / 1ps
// Package for the priority ownership arbiter: transaction payload types,
// request kinds, status codes and the scan control. No dependencies.
package poa_pkg;

    // Widths of the transaction fields
    localparam int KIND_W  = 2;
    localparam int ID_W    = 4;
    localparam int LEVEL_W = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACQUIRE   = 2'd0,
        KIND_RELEASE   = 2'd1,
        KIND_SHOW      = 2'd2,
        KIND_REACQUIRE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_DUP      = 2'd2,
        STATUS_NOT_HELD = 2'd3
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic [ID_W-1:0]    holder_id;
        logic [LEVEL_W-1:0] level;
    } in_t;

    typedef struct packed {
        logic               granted;
        logic               owner_valid;
        logic [ID_W-1:0]    owner_id;
        logic [LEVEL_W-1:0] owner_level;
        status_t            status;
    } out_t;

    // Control from the sequencer to the table scan unit
    typedef struct packed {
        logic clear;
        logic check;
    } scan_ctl_t;

endpackage

>>> design/priority_ownership_arbiter_core.sv
`timescale 1ns / 1ps
// Priority ownership arbiter top level: sequencer, holder table and output
// register. Depends on poa_pkg, poa_ram and poa_scan.
//
// Usage:
//   Requests arrive on the s_ channel (valid/ready, payload in_t): acquire,
//   release, show or reacquire for one holder id with a priority level.
//   Each request returns exactly one transaction on the m_ channel (out_t):
//   whether the id owns the resource, the owner's id and level, and a status.
//   The owner is the holder with the largest level, earliest in table order
//   on a tie.
//   A request scans the table once through the single RAM read port; a
//   release, or a reacquire that changes the level, then closes the gap
//   by moving the later entries down one place at one entry a cycle.
//   One request is in work at a time; s_ready is high only while idle.
//   An output register holds the result, so the next request is accepted
//   while a result still waits; if the receiver stalls, the following
//   request finishes and waits until the register is taken.
//   Reset empties the table at once; table entries need no clearing.
module priority_ownership_arbiter_core #(
    parameter int MAX_HOLDERS = 8,
    parameter int ID_BITS     = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  poa_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output poa_pkg::out_t m_data
);
    import poa_pkg::*;

    localparam int AW  = (MAX_HOLDERS > 1) ? $clog2(MAX_HOLDERS) : 1;
    localparam int CW  = $clog2(MAX_HOLDERS + 1);
    localparam int IDW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam int RW  = IDW + LEVEL_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_SHIFT  = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      cur_reg, cur_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pend_idx_reg, pend_idx_next;
    logic               append_reg, append_next;
    kind_t              kind_reg;
    logic [IDW-1:0]     id_reg;
    logic [LEVEL_W-1:0] lvl_reg;
    out_t               res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;

    // Table port signals
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [RW-1:0]      wr_data;
    logic               rd_en;
    logic [RW-1:0]      rd_data;
    logic [CW-1:0]      cnt_m1;

    // Scan results
    scan_ctl_t          sc_ctl;
    logic               sc_held;
    logic [AW-1:0]      sc_pos;
    logic [LEVEL_W-1:0] sc_hlvl;
    logic               sc_bv;
    logic [AW-1:0]      sc_bidx;
    logic [IDW-1:0]     sc_bid;
    logic [LEVEL_W-1:0] sc_blvl;

    // Decision terms
    logic               held_wins;
    logic               all_v, base_v, own_v;
    logic [IDW-1:0]     all_id, base_id, own_id;
    logic [LEVEL_W-1:0] all_lvl, base_lvl, own_lvl;
    logic               removing, adding_new, acq_ok;
    status_t            st;
    logic               accept;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign cnt_m1  = count_reg - CW'(1);

    poa_ram #(
        .WIDTH(RW),
        .DEPTH(MAX_HOLDERS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (cur_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign sc_ctl.clear = accept;
    assign sc_ctl.check = pend_reg && (state_reg == ST_SCAN);

    poa_scan #(
        .AW (AW),
        .IDW(IDW)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (sc_ctl),
        .entry_idx  (pend_idx_reg),
        .entry_id   (rd_data[RW-1:LEVEL_W]),
        .entry_level(rd_data[LEVEL_W-1:0]),
        .req_id     (id_reg),
        .held       (sc_held),
        .held_pos   (sc_pos),
        .held_level (sc_hlvl),
        .best_valid (sc_bv),
        .best_idx   (sc_bidx),
        .best_id    (sc_bid),
        .best_level (sc_blvl)
    );

    // Work out status and the new owner from the scan results
    always_comb begin
        held_wins = sc_held && (!sc_bv || (sc_hlvl > sc_blvl) ||
                    ((sc_hlvl == sc_blvl) && (sc_pos < sc_bidx)));
        all_v     = sc_held || sc_bv;
        all_id    = held_wins ? id_reg : sc_bid;
        all_lvl   = held_wins ? sc_hlvl : sc_blvl;

        st         = STATUS_OK;
        removing   = 1'b0;
        adding_new = 1'b0;
        acq_ok     = 1'b0;
        unique case (kind_reg)
            KIND_ACQUIRE: begin
                if (sc_held) begin
                    st = STATUS_DUP;
                end else if (count_reg == CW'(MAX_HOLDERS)) begin
                    st = STATUS_FULL;
                end else begin
                    acq_ok     = 1'b1;
                    adding_new = 1'b1;
                end
            end
            KIND_RELEASE: begin
                if (!sc_held) begin
                    st = STATUS_NOT_HELD;
                end else begin
                    removing = 1'b1;
                end
            end
            KIND_SHOW: begin
                st = STATUS_OK;
            end
            KIND_REACQUIRE: begin
                if (!sc_held) begin
                    st = STATUS_NOT_HELD;
                end else if (sc_hlvl != lvl_reg) begin
                    removing   = 1'b1;
                    adding_new = 1'b1;
                end
            end
        endcase

        base_v   = removing ? sc_bv : all_v;
        base_id  = removing ? sc_bid : all_id;
        base_lvl = removing ? sc_blvl : all_lvl;
        if (adding_new && (!base_v || (lvl_reg > base_lvl))) begin
            own_v   = 1'b1;
            own_id  = id_reg;
            own_lvl = lvl_reg;
        end else begin
            own_v   = base_v;
            own_id  = base_id;
            own_lvl = base_lvl;
        end

        res_next.granted     = own_v && (own_id == id_reg);
        res_next.owner_valid = own_v;
        res_next.owner_id    = own_v ? ID_W'(own_id) : '0;
        res_next.owner_level = own_v ? own_lvl : '0;
        res_next.status      = st;
    end

    // Sequencer: scan, decide, close the gap, deliver
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        cur_next      = cur_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        append_next   = append_reg;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = count_reg[AW-1:0];
        wr_data       = {id_reg, lvl_reg};
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cur_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Issue one read a cycle; data is checked the cycle after
                if (cur_reg < count_reg) begin
                    rd_en         = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = cur_reg[AW-1:0];
                    cur_next      = cur_reg + CW'(1);
                end else if (!pend_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                append_next = adding_new;
                if (acq_ok) begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                if (removing) begin
                    cur_next   = CW'(sc_pos) + CW'(1);
                    state_next = ST_SHIFT;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_SHIFT: begin
                // Move later entries down one place, then drop or refill the tail
                if (pend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = pend_idx_reg - AW'(1);
                    wr_data = rd_data;
                end
                if (cur_reg < count_reg) begin
                    rd_en         = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = cur_reg[AW-1:0];
                    cur_next      = cur_reg + CW'(1);
                end else if (!pend_reg) begin
                    if (append_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = cnt_m1[AW-1:0];
                    end else begin
                        count_next = cnt_m1;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold request, cursor and result payload
    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        pend_idx_reg <= pend_idx_next;
        append_reg   <= append_next;
        m_data_reg   <= m_data_next;
        if (state_reg == ST_DECIDE) begin
            res_reg <= res_next;
        end
        if (accept) begin
            kind_reg <= s_data.kind;
            id_reg   <= s_data.holder_id[IDW-1:0];
            lvl_reg  <= s_data.level;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The table never holds more than its depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_HOLDERS))
        else $error("holder count beyond table depth");

    // A full status is only given when the table is full
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DECIDE) && (res_next.status == STATUS_FULL))
        |-> (count_reg == CW'(MAX_HOLDERS)))
        else $error("full status with free slots");

    // The reported owner matches the table occupancy
    a_owner_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |-> (res_reg.owner_valid == (count_reg != '0)))
        else $error("owner flag disagrees with holder count");

    // The table is not written while it is being scanned
    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !wr_en)
        else $error("table write during scan");

    // An accepted request always starts with a scan
    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_SCAN))
        else $error("request did not start a scan");

endmodule

>>> design/poa_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module poa_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 8
) (
    input  logic                                         aclk,
    input  logic                                         wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic                                         rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/poa_scan.sv
`timescale 1ns / 1ps
// Table scan unit: one compare per table entry, tracking the requested id
// and the first maximum among the other holders. Depends on poa_pkg.
module poa_scan #(
    parameter int AW  = 3,
    parameter int IDW = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  poa_pkg::scan_ctl_t        ctl,
    input  logic [AW-1:0]             entry_idx,
    input  logic [IDW-1:0]            entry_id,
    input  logic [poa_pkg::LEVEL_W-1:0] entry_level,
    input  logic [IDW-1:0]            req_id,
    output logic                      held,
    output logic [AW-1:0]             held_pos,
    output logic [poa_pkg::LEVEL_W-1:0] held_level,
    output logic                      best_valid,
    output logic [AW-1:0]             best_idx,
    output logic [IDW-1:0]            best_id,
    output logic [poa_pkg::LEVEL_W-1:0] best_level
);
    import poa_pkg::*;

    logic               held_reg, held_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [LEVEL_W-1:0] hlvl_reg, hlvl_next;
    logic               bv_reg, bv_next;
    logic [AW-1:0]      bidx_reg, bidx_next;
    logic [IDW-1:0]     bid_reg, bid_next;
    logic [LEVEL_W-1:0] blvl_reg, blvl_next;

    // Compare one entry: match the id, else keep the strictly larger level
    always_comb begin
        held_next = held_reg;
        pos_next  = pos_reg;
        hlvl_next = hlvl_reg;
        bv_next   = bv_reg;
        bidx_next = bidx_reg;
        bid_next  = bid_reg;
        blvl_next = blvl_reg;
        if (ctl.clear) begin
            held_next = 1'b0;
            bv_next   = 1'b0;
        end else if (ctl.check) begin
            if (entry_id == req_id) begin
                held_next = 1'b1;
                pos_next  = entry_idx;
                hlvl_next = entry_level;
            end else if (!bv_reg || (entry_level > blvl_reg)) begin
                bv_next   = 1'b1;
                bidx_next = entry_idx;
                bid_next  = entry_id;
                blvl_next = entry_level;
            end
        end
    end

    // Hold tracker flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= 1'b0;
            bv_reg   <= 1'b0;
        end else begin
            held_reg <= held_next;
            bv_reg   <= bv_next;
        end
    end

    // Hold tracker payload
    always_ff @(posedge aclk) begin
        pos_reg  <= pos_next;
        hlvl_reg <= hlvl_next;
        bidx_reg <= bidx_next;
        bid_reg  <= bid_next;
        blvl_reg <= blvl_next;
    end

    assign held       = held_reg;
    assign held_pos   = pos_reg;
    assign held_level = hlvl_reg;
    assign best_valid = bv_reg;
    assign best_idx   = bidx_reg;
    assign best_id    = bid_reg;
    assign best_level = blvl_reg;

endmodule
